// ----- rtl/servo_smoothed_pwm_driver_core_defines.svh -----
// assertion macros used by the sspd_back module
`ifndef SERVO_SMOOTHED_PWM_DRIVER_CORE_DEFINES_SVH
`define SERVO_SMOOTHED_PWM_DRIVER_CORE_DEFINES_SVH

// condition holds at every clock edge outside reset
`define SSPD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define SSPD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define SSPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sspd_pkg.sv -----
package sspd_pkg;

   // default parameter values
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int STEP_FRAC_BITS  = 16;
   localparam int FIFO_DEPTH      = 2;

   // field widths
   localparam int REQ_W       = 2;
   localparam int ANGLE_W     = 17;
   localparam int STEP_W      = 17;
   localparam int PERIOD_W    = 16;
   localparam int LEVEL_W     = 13;
   localparam int POS_OUT_W   = 16;
   localparam int CSR_INDEX_W = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_GOAL  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PLACE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD = 2'd1;

   // register reset values
   localparam logic [STEP_W-1:0]   STEP_RESET   = 17'd6554;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20000;

   // servo timing constants, pulse widths in microseconds
   localparam int US_MIN   = 500;
   localparam int US_MAX   = 2400;
   localparam int FRAME_US = 20000;
   localparam int DEG_SPAN = 180;
   localparam int HOME_DEG = 90;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_GOAL,
      OP_PLACE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [ANGLE_W-1:0] angle;
   } cmd_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   pwm_level;
      logic [POS_OUT_W-1:0] position;
      logic                 settled;
   } rsp_type;

   // divisor of the level scaling: frame length times angle span
   function automatic longint level_den(int frac);
      return (longint'(FRAME_US) * longint'(DEG_SPAN)) << frac;
   endfunction

   // pulse offset of the minimum angle in the same scale
   function automatic longint level_ofs(int frac);
      return (longint'(US_MIN) * longint'(DEG_SPAN)) << frac;
   endfunction

   // largest position value
   function automatic longint max_pos(int frac);
      return longint'(DEG_SPAN) << frac;
   endfunction

   function automatic int pos_width(int frac);
      return $clog2(max_pos(frac) + 1);
   endfunction

   function automatic int num_width(int frac);
      return $clog2(level_ofs(frac) + max_pos(frac) * longint'(US_MAX - US_MIN) + 1);
   endfunction

   // dividend width: quotient bits above the divisor width
   function automatic int div_width(int frac);
      return $clog2(level_den(frac) + 1) + LEVEL_W;
   endfunction

endpackage

// ----- rtl/sspd_fifo.sv -----
module sspd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sspd_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/sspd_front.sv -----
module sspd_front #(
   parameter int FIFO_DEPTH = sspd_pkg::FIFO_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [sspd_pkg::REQ_W-1:0]           req_type,
   input  logic signed [sspd_pkg::ANGLE_W-1:0]  req_angle_value,
   output logic                                 cmd_valid,
   input  logic                                 cmd_pop,
   output sspd_pkg::cmd_type                    cmd
);

   sspd_pkg::cmd_type cmd_in;
   logic              cmd_empty;

   // request classification
   always_comb begin
      cmd_in.angle = req_angle_value;
      case (req_type)
         sspd_pkg::REQ_TICK:  cmd_in.op = sspd_pkg::OP_TICK;
         sspd_pkg::REQ_GOAL:  cmd_in.op = sspd_pkg::OP_GOAL;
         sspd_pkg::REQ_PLACE: cmd_in.op = sspd_pkg::OP_PLACE;
         default:             cmd_in.op = sspd_pkg::OP_NONE;
      endcase
   end

   // command queue towards the sequencer
   sspd_fifo #(
      .WIDTH ($bits(sspd_pkg::cmd_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_in),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

   assign cmd_valid = ~cmd_empty;

endmodule

// ----- rtl/sspd_divider.sv -----
module sspd_divider #(
   parameter int ANGLE_FRAC_BITS = sspd_pkg::ANGLE_FRAC_BITS
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               start,
   input  logic [sspd_pkg::div_width(ANGLE_FRAC_BITS)-1:0]    dividend,
   output logic                                               done,
   output logic [sspd_pkg::LEVEL_W-1:0]                       quotient
);

   localparam int     W_DIV = sspd_pkg::div_width(ANGLE_FRAC_BITS);
   localparam int     Q_W   = sspd_pkg::LEVEL_W;
   // frame length times angle span is an odd factor shifted up by this many bits
   localparam int     TWOS  = 7;
   localparam longint ODD   =
      (longint'(sspd_pkg::FRAME_US) * longint'(sspd_pkg::DEG_SPAN)) >> TWOS;
   localparam int     SHIFT = ANGLE_FRAC_BITS + TWOS;
   localparam int     D_W   = W_DIV - SHIFT;
   // reciprocal scale: exact floor for every dividend of D_W bits
   localparam int     K     = D_W + $clog2(ODD);
   localparam longint RECIP = ((longint'(1) << K) + ODD - 1) / ODD;
   localparam int     R_W   = $clog2(RECIP + 1);
   localparam int     P_W   = D_W + R_W;
   localparam logic [R_W-1:0] RECIP_V = R_W'(RECIP);

   logic [D_W-1:0] d_ff;
   logic [Q_W-1:0] q_ff;
   logic           mul_ff, done_ff;
   logic [P_W-1:0] prod;

   assign prod     = P_W'(d_ff) * P_W'(RECIP_V);
   assign done     = done_ff;
   assign quotient = q_ff;

   // two-step control: shift on start, reciprocal multiply in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         done_ff <= mul_ff;
      end
   end

   // power-of-two part drops by a shift, the odd part by the reciprocal
   always_ff @(posedge clock) begin
      if (start) begin
         d_ff <= dividend[SHIFT +: D_W];
      end
      if (mul_ff) begin
         q_ff <= prod[K +: Q_W];
      end
   end

endmodule

// ----- rtl/sspd_back.sv -----
`include "servo_smoothed_pwm_driver_core_defines.svh"

module sspd_back #(
   parameter int ANGLE_FRAC_BITS = sspd_pkg::ANGLE_FRAC_BITS,
   parameter int STEP_FRAC_BITS  = sspd_pkg::STEP_FRAC_BITS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            cmd_valid,
   input  sspd_pkg::cmd_type                               cmd,
   output logic                                            cmd_pop,
   input  logic [sspd_pkg::STEP_W-1:0]                     step_fraction,
   input  logic [sspd_pkg::PERIOD_W-1:0]                   period_count,
   input  logic                                            rsp_full,
   output logic                                            rsp_push,
   output sspd_pkg::rsp_type                               rsp,
   output logic                                            div_start,
   output logic [sspd_pkg::div_width(ANGLE_FRAC_BITS)-1:0] dividend,
   input  logic                                            div_done,
   input  logic [sspd_pkg::LEVEL_W-1:0]                    quotient
);

   localparam int     POS_W     = sspd_pkg::pos_width(ANGLE_FRAC_BITS);
   localparam int     NUM_W     = sspd_pkg::num_width(ANGLE_FRAC_BITS);
   localparam int     W_DIV     = sspd_pkg::div_width(ANGLE_FRAC_BITS);
   localparam int     F_W       = STEP_FRAC_BITS + 1;
   localparam int     PROD_W    = POS_W + F_W;
   localparam int     LVL_W     = NUM_W + sspd_pkg::PERIOD_W;
   localparam longint MAX_POS   = sspd_pkg::max_pos(ANGLE_FRAC_BITS);
   localparam longint ONE_DEG   = longint'(1) << ANGLE_FRAC_BITS;
   localparam longint HOME_POS  = longint'(sspd_pkg::HOME_DEG) << ANGLE_FRAC_BITS;
   localparam longint FULL_STEP = longint'(1) << STEP_FRAC_BITS;
   localparam longint NUM_OFS   = sspd_pkg::level_ofs(ANGLE_FRAC_BITS);
   localparam longint HALF_DEN  = sspd_pkg::level_den(ANGLE_FRAC_BITS) / 2;
   localparam int     US_SPAN   = sspd_pkg::US_MAX - sspd_pkg::US_MIN;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_UPDATE,
      ST_LEVEL,
      ST_SCALE,
      ST_DIV
   } state_type;

   state_type            state_ff, state_in;
   sspd_pkg::op_type     op_ff, op_in;
   logic [POS_W-1:0]     now_ff, now_in;
   logic [POS_W-1:0]     goal_ff, goal_in;
   logic [POS_W-1:0]     ang_ff, ang_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic                 small_ff, small_in;
   logic                 settled_ff, settled_in;
   logic [NUM_W-1:0]     num_ff, num_in;

   logic signed [31:0]   ang32;
   logic [POS_W-1:0]     ang_clamp;
   logic signed [POS_W:0] gap;
   logic [POS_W-1:0]     mag;
   logic [31:0]          sf32;
   logic [F_W-1:0]       f_cl;
   logic [POS_W-1:0]     move;
   logic [LVL_W-1:0]     lvl_prod;

   // angle clamp to the servo range
   always_comb begin
      ang32 = 32'($signed(cmd.angle));
      if (ang32 < 32'sd0) begin
         ang_clamp = '0;
      end else if (ang32 > 32'(MAX_POS)) begin
         ang_clamp = POS_W'(MAX_POS);
      end else begin
         ang_clamp = POS_W'(ang32);
      end
   end

   // gap between goal and position
   assign gap  = $signed({1'b0, goal_ff}) - $signed({1'b0, now_ff});
   assign mag  = gap[POS_W] ? POS_W'(-gap) : POS_W'(gap);

   // step fraction limited to a full step
   assign sf32 = 32'(step_fraction);
   assign f_cl = (sf32 > 32'(FULL_STEP)) ? F_W'(FULL_STEP) : F_W'(sf32);
   assign move = prod_ff[STEP_FRAC_BITS +: POS_W];

   // pulse numerator times period, plus half the divisor for rounding
   assign lvl_prod = LVL_W'(num_ff) * LVL_W'(period_count);
   assign dividend = W_DIV'(lvl_prod) + W_DIV'(HALF_DEN);

   assign cmd_pop       = (state_ff == ST_IDLE) & cmd_valid & ~rsp_full;
   assign div_start     = (state_ff == ST_SCALE);
   assign rsp_push      = (state_ff == ST_DIV) & div_done;
   assign rsp.pwm_level = quotient;
   assign rsp.position  = sspd_pkg::POS_OUT_W'(now_ff);
   assign rsp.settled   = settled_ff;

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      now_in     = now_ff;
      goal_in    = goal_ff;
      ang_in     = ang_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      small_in   = small_ff;
      settled_in = settled_ff;
      num_in     = num_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               op_in    = cmd.op;
               ang_in   = ang_clamp;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(mag) * PROD_W'(f_cl);
            neg_in   = gap[POS_W];
            small_in = (mag <= POS_W'(ONE_DEG));
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            case (op_ff)
               sspd_pkg::OP_TICK: begin
                  if (small_ff) begin
                     now_in = goal_ff;
                  end else if (neg_ff) begin
                     now_in = now_ff - move;
                  end else begin
                     now_in = now_ff + move;
                  end
               end
               sspd_pkg::OP_GOAL: begin
                  goal_in = ang_ff;
               end
               sspd_pkg::OP_PLACE: begin
                  now_in  = ang_ff;
                  goal_in = ang_ff;
               end
               default: begin
                  now_in = now_ff;
               end
            endcase
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            num_in     = NUM_W'(NUM_OFS) + NUM_W'(now_ff) * NUM_W'(US_SPAN);
            settled_in = (mag < POS_W'(ONE_DEG));
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         now_ff   <= POS_W'(HOME_POS);
         goal_ff  <= POS_W'(HOME_POS);
      end else begin
         state_ff <= state_in;
         now_ff   <= now_in;
         goal_ff  <= goal_in;
      end
      op_ff      <= op_in;
      ang_ff     <= ang_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      small_ff   <= small_in;
      settled_ff <= settled_in;
      num_ff     <= num_in;
   end

   // position and goal stay inside the servo range
   `SSPD_ASSERT_ALWAYS(a_pos_range, now_ff <= POS_W'(MAX_POS), "position out of range")
   `SSPD_ASSERT_ALWAYS(a_goal_range, goal_ff <= POS_W'(MAX_POS), "goal out of range")
   // divider finishes only while the sequencer waits for it
   `SSPD_ASSERT_IMPLIES(a_div_sync, div_done, state_ff == ST_DIV, "divider done out of step")
   // a snapping tick lands exactly on the goal
   `SSPD_ASSERT_NEXT(a_snap, (state_ff == ST_UPDATE) && (op_ff == sspd_pkg::OP_TICK) && small_ff, now_ff == goal_ff, "snap missed goal")
   // place leaves position and goal equal
   `SSPD_ASSERT_NEXT(a_place, (state_ff == ST_UPDATE) && (op_ff == sspd_pkg::OP_PLACE), now_ff == goal_ff, "place left a gap")

endmodule

// ----- rtl/servo_smoothed_pwm_driver_core.sv -----
// Servo position smoother with PWM compare output. Requests enter a queue (req_push/req_full)
// and each one gives exactly one result on the result queue (rsp_pop/rsp_empty), in order:
// tick moves the position a step_fraction share of the gap towards the goal and snaps
// within one degree, set-goal and place take a clamped angle. The sequencer handles one
// request at a time and takes no new one before its result is pushed: it takes the request
// from the request queue, applies it and forms the pulse numerator, then runs the level
// scaling, which divides by the constant divisor with a shift and a reciprocal multiplication.
// Request and result queues of FIFO_DEPTH entries let both sides stall on their own.
// Register writes on the csr_ port are always accepted and are expected only while the
// block is idle.
module servo_smoothed_pwm_driver_core #(
   parameter int ANGLE_FRAC_BITS = sspd_pkg::ANGLE_FRAC_BITS,
   parameter int STEP_FRAC_BITS  = sspd_pkg::STEP_FRAC_BITS,
   parameter int FIFO_DEPTH      = sspd_pkg::FIFO_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [sspd_pkg::REQ_W-1:0]          req_type,
   input  logic signed [sspd_pkg::ANGLE_W-1:0] req_angle_value,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [sspd_pkg::LEVEL_W-1:0]        rsp_pwm_level,
   output logic [sspd_pkg::POS_OUT_W-1:0]      rsp_position,
   output logic                                rsp_settled,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sspd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sspd_pkg::STEP_W-1:0]         csr_data
);

   localparam int W_DIV = sspd_pkg::div_width(ANGLE_FRAC_BITS);

   logic [sspd_pkg::STEP_W-1:0]   step_ff;
   logic [sspd_pkg::PERIOD_W-1:0] period_ff;
   logic                          cmd_valid, cmd_pop;
   sspd_pkg::cmd_type             cmd;
   logic                          rsp_full, rsp_push;
   sspd_pkg::rsp_type             rsp_wr, rsp_rd;
   logic                          div_start, div_done;
   logic [W_DIV-1:0]              dividend;
   logic [sspd_pkg::LEVEL_W-1:0]  quotient;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= sspd_pkg::STEP_RESET;
         period_ff <= sspd_pkg::PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sspd_pkg::CSR_STEP:   step_ff   <= csr_data;
            sspd_pkg::CSR_PERIOD: period_ff <= csr_data[sspd_pkg::PERIOD_W-1:0];
            default:              step_ff   <= step_ff;
         endcase
      end
   end

   // front: accept and classify requests
   sspd_front #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_type        (req_type),
      .req_angle_value (req_angle_value),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd)
   );

   // back: apply requests and form results
   sspd_back #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .STEP_FRAC_BITS  (STEP_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .step_fraction (step_ff),
      .period_count  (period_ff),
      .rsp_full      (rsp_full),
      .rsp_push      (rsp_push),
      .rsp           (rsp_wr),
      .div_start     (div_start),
      .dividend      (dividend),
      .div_done      (div_done),
      .quotient      (quotient)
   );

   // level scaling divider
   sspd_divider #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .done     (div_done),
      .quotient (quotient)
   );

   // result queue
   sspd_fifo #(
      .WIDTH ($bits(sspd_pkg::rsp_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_pwm_level = rsp_rd.pwm_level;
   assign rsp_position  = rsp_rd.position;
   assign rsp_settled   = rsp_rd.settled;

endmodule

// ----- sim/tb_servo_smoothed_pwm_driver_core.sv -----
module tb_servo_smoothed_pwm_driver_core;
   import sspd_pkg::*;

   localparam int ONE_DEG = 1 << ANGLE_FRAC_BITS;
   localparam int MAX_POS = DEG_SPAN * ONE_DEG;
   localparam int HOME_POS = HOME_DEG * ONE_DEG;
   localparam longint FULL_STEP = longint'(1) << STEP_FRAC_BITS;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT_ANGLES [6] = '{-65536, 65535, 0, MAX_POS, MAX_POS + 1, -1};

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [REQ_W-1:0]            req_type = REQ_TICK;
   logic signed [ANGLE_W-1:0]   req_angle_value = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [LEVEL_W-1:0]          rsp_pwm_level;
   logic [POS_OUT_W-1:0]        rsp_position;
   logic                        rsp_settled;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_STEP;
   logic [STEP_W-1:0]           csr_data = '0;

   // servo model state and register copies
   int                          pos_now = HOME_POS;
   int                          pos_goal = HOME_POS;
   logic [STEP_W-1:0]           step_cfg = STEP_RESET;
   logic [PERIOD_W-1:0]         period_cfg = PERIOD_RESET;

   cmd_type                     cmd_backlog[$];
   rsp_type                     awaited_rsp[$];

   int                          fail_count = 0;
   int                          cycle_count = 0;
   int                          phase_no = 0;

   // sender pacing
   bit                          offering;
   int                          burst_left = 0;
   int                          gap_left = 0;

   // receiver pacing
   int                          hold_left = 0;
   int                          pattern_left = 0;
   int                          stall_mode = 0;
   int                          seen_phase = 0;
   int                          phase_reads = 0;
   rsp_type                     want;

   servo_smoothed_pwm_driver_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_type        (req_type),
      .req_angle_value (req_angle_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pwm_level   (rsp_pwm_level),
      .rsp_position    (rsp_position),
      .rsp_settled     (rsp_settled),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // clamp a signed request angle into 0..180 degrees
   function automatic int clamp_deg(logic signed [ANGLE_W-1:0] a);
      int v;
      v = a;
      if (v < 0) return 0;
      if (v > MAX_POS) return MAX_POS;
      return v;
   endfunction

   // pwm level, position and settled flag for the current state
   function automatic rsp_type servo_reading();
      longint num;
      longint den;
      longint lvl;
      int     gap;
      rsp_type r;
      num = longint'(US_MIN * DEG_SPAN) * ONE_DEG + longint'(pos_now) * (US_MAX - US_MIN);
      den = longint'(FRAME_US * DEG_SPAN) * ONE_DEG;
      lvl = (num * longint'(period_cfg) + den / 2) / den;
      gap = pos_goal - pos_now;
      if (gap < 0) gap = -gap;
      r.pwm_level = lvl[LEVEL_W-1:0];
      r.position = pos_now[POS_OUT_W-1:0];
      r.settled = (gap < ONE_DEG);
      return r;
   endfunction

   // apply one request to the servo state and give the reading after it
   function automatic rsp_type servo_advance(cmd_type c);
      int     gap;
      int     mag;
      int     move;
      longint frac;
      case (c.op)
         OP_TICK: begin
            gap = pos_goal - pos_now;
            mag = (gap < 0) ? -gap : gap;
            frac = (step_cfg > FULL_STEP) ? FULL_STEP : longint'(step_cfg);
            if (mag <= ONE_DEG) begin
               pos_now = pos_goal;
            end else begin
               move = int'((longint'(mag) * frac) >>> STEP_FRAC_BITS);
               pos_now += (gap < 0) ? -move : move;
            end
         end
         OP_GOAL: pos_goal = clamp_deg(c.angle);
         OP_PLACE: begin
            pos_now = clamp_deg(c.angle);
            pos_goal = pos_now;
         end
         default: ;
      endcase
      return servo_reading();
   endfunction

   task automatic report_mismatch(string field, logic [15:0] exp_val, logic [15:0] got_val);
      fail_count++;
      $display("[cycle %0d] %s mismatch: expected %0d, got %0d",
               cycle_count, field, exp_val, got_val);
   endtask

   task automatic add_cmd(op_type op, int angle);
      cmd_type c;
      c.op = op;
      c.angle = ANGLE_W'(angle);
      cmd_backlog.push_back(c);
   endtask

   // mostly in-range angles, now and then the limits or raw bits
   function automatic int rand_angle();
      case ($urandom_range(0, 9))
         0: return int'($signed(ANGLE_W'($urandom)));
         1: return LIMIT_ANGLES[$urandom_range(0, 5)];
         default: return $urandom_range(0, MAX_POS);
      endcase
   endfunction

   // one register transfer; the model copy follows on acceptance
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [STEP_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STEP: step_cfg = val;
         CSR_PERIOD: period_cfg = val[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [STEP_W-1:0] step, logic [PERIOD_W-1:0] period,
                             bit with_spare);
      @(posedge clock);
      if (with_spare) begin
         write_reg(CSR_SPARE_LO, STEP_W'($urandom));
         write_reg(CSR_SPARE_HI, STEP_W'($urandom));
      end
      write_reg(CSR_STEP, step);
      write_reg(CSR_PERIOD, STEP_W'(period));
      csr_valid <= 1'b0;
   endtask

   // wait for the backlog and all readings to drain, then let the core go quiet
   task automatic wait_idle();
      do @(negedge clock); while (cmd_backlog.size() != 0 || awaited_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // moves: optional place, a goal, then a run of ticks; some noise between
   task automatic fill_random(int count);
      int made;
      int base;
      int ticks;
      made = 0;
      @(negedge clock);
      phase_no++;
      while (made < count) begin
         if ($urandom_range(0, 9) < 8) begin
            base = rand_angle();
            if ($urandom_range(0, 1)) begin
               add_cmd(OP_PLACE, base);
               made++;
            end
            if ($urandom_range(0, 2) == 0)
               add_cmd(OP_GOAL, base + $urandom_range(0, 1000) - 500);
            else
               add_cmd(OP_GOAL, rand_angle());
            made++;
            ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
            repeat (ticks) add_cmd(OP_TICK, int'($urandom));
            made += ticks;
         end else begin
            add_cmd(op_type'($urandom_range(0, 3)), int'($urandom));
            made++;
         end
      end
   endtask

   // sender: bursts of transfers with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         offering = req_push;
         if (req_push && !req_full) begin
            awaited_rsp.push_back(servo_advance(cmd_backlog.pop_front()));
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               req_push <= 1'b1;
               req_type <= cmd_backlog[0].op;
               req_angle_value <= cmd_backlog[0].angle;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver: check each transfer, stall in changing patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (phase_no != seen_phase) begin
            seen_phase = phase_no;
            phase_reads = 0;
         end
         if (rsp_pop && !rsp_empty) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("unawaited result, position", '0, rsp_position);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_pwm_level !== want.pwm_level)
                  report_mismatch("pwm_level", want.pwm_level, rsp_pwm_level);
               if (rsp_position !== want.position)
                  report_mismatch("position", want.position, rsp_position);
               if (rsp_settled !== want.settled)
                  report_mismatch("settled", want.settled, rsp_settled);
            end
            phase_reads++;
            // long hold-off in two phases so both queues fill and push stalls
            if (phase_reads == 20 && (phase_no == 2 || phase_no == 5))
               hold_left = HOLD_CYCLES;
         end
         if (pattern_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 150);
         end else begin
            pattern_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: limits, clamping, one-degree edges, unused request kind
      @(negedge clock);
      add_cmd(OP_TICK, 0);
      add_cmd(OP_PLACE, 0);
      add_cmd(OP_PLACE, MAX_POS);
      add_cmd(OP_GOAL, -65536);
      add_cmd(OP_TICK, 65535);
      add_cmd(OP_TICK, -1);
      add_cmd(OP_GOAL, 65535);
      add_cmd(OP_PLACE, -1);
      add_cmd(OP_PLACE, MAX_POS + 1);
      add_cmd(OP_GOAL, MAX_POS - ONE_DEG);
      add_cmd(OP_TICK, 0);
      add_cmd(OP_GOAL, MAX_POS - 2 * ONE_DEG - 1);
      add_cmd(OP_TICK, 0);
      add_cmd(OP_NONE, 12345);
      add_cmd(OP_NONE, -1);
      add_cmd(OP_PLACE, HOME_POS);
      add_cmd(OP_GOAL, HOME_POS + ONE_DEG - 1);
      add_cmd(OP_TICK, 0);
      add_cmd(OP_GOAL, 1);
      add_cmd(OP_TICK, 0);
      add_cmd(OP_TICK, 0);
      add_cmd(OP_PLACE, 65535);
      wait_idle();

      // zero step and zero period
      set_config('0, '0, 1'b0);
      fill_random(80);
      wait_idle();

      // full step, widest period
      set_config(STEP_W'(FULL_STEP), '1, 1'b0);
      fill_random(100);
      wait_idle();

      // oversized step, smallest nonzero period
      set_config('1, 16'd1, 1'b0);
      fill_random(80);
      wait_idle();

      // spare indexes touched, then the finest step
      set_config(17'd1, PERIOD_RESET, 1'b1);
      fill_random(80);
      wait_idle();

      repeat (3) begin
         set_config(STEP_W'($urandom_range(0, 131071)), PERIOD_W'($urandom), 1'b0);
         fill_random(60);
         wait_idle();
      end

      // back to the reset settings
      set_config(STEP_RESET, PERIOD_RESET, 1'b0);
      fill_random(50);
      wait_idle();

      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
